[src/rcfh_pkg.sv]
// Shared types and constants for the ray/circle first-hit pipeline.
// No dependencies.
package rcfh_pkg;

    localparam int TCA_W = 44;
    localparam int SQ_SAT_BIT = 62;
    localparam logic [31:0] MISS_DIST = 32'h7FFF_FFFF;

    typedef struct packed {
        logic              valid;
        logic              in_circle;
        logic              live;
        logic [30:0]       maxd;
        logic [TCA_W-1:0]  tca;
    } t_side;

endpackage

[src/rcfh_if.sv]
// Valid/ready channel interfaces for the ray/circle first-hit block.
// No dependencies.
interface rcfh_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] ray_origin_x;
    logic signed [31:0] ray_origin_y;
    logic signed [17:0] ray_dir_x;
    logic signed [17:0] ray_dir_y;
    logic [30:0]        ray_max_distance;
    logic signed [31:0] circle_center_x;
    logic signed [31:0] circle_center_y;
    logic [30:0]        circle_radius_sq;

    modport source (output valid, ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y,
                    ray_max_distance, circle_center_x, circle_center_y,
                    circle_radius_sq, input ready);
    modport sink (input valid, ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y,
                  ray_max_distance, circle_center_x, circle_center_y,
                  circle_radius_sq, output ready);
endinterface

interface rcfh_out_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] hit_distance;
    logic               origin_inside;

    modport source (output valid, hit, hit_distance, origin_inside, input ready);
    modport sink (input valid, hit, hit_distance, origin_inside, output ready);
endinterface

[src/rcfh_front.sv]
// Front stages: offset, projection, squared lengths and squared half-chord.
// Depends on rcfh_pkg.
module rcfh_front
    import rcfh_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_ox,
    input  logic signed [31:0] i_oy,
    input  logic signed [17:0] i_dx,
    input  logic signed [17:0] i_dy,
    input  logic [30:0]        i_maxd,
    input  logic signed [31:0] i_cx,
    input  logic signed [31:0] i_cy,
    input  logic [30:0]        i_r2,
    output t_side              o_side,
    output logic [62:0]        o_thc
);

    localparam int TW   = 51 - FRAC_BITS;
    localparam int K    = (TW + 1) / 2;
    localparam int HW   = TW - K;
    localparam int LMW  = 67 - FRAC_BITS;
    localparam int SQW  = (2 * TW > 64) ? 2 * TW : 64;

    logic              r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic signed [32:0] r1_lx, r1_ly;
    logic signed [17:0] r1_dx, r1_dy;
    logic [30:0]       r1_maxd, r2_maxd, r3_maxd, r4_maxd, r5_maxd, r6_maxd;
    logic [30:0]       r1_r2, r2_r2, r3_r2, r4_r2, r5_r2;
    logic signed [50:0] r2_px, r2_py;
    logic [65:0]       r2_sx, r2_sy;
    logic              r3_neg, r4_neg, r5_neg;
    logic              r3_in, r4_in, r5_in, r6_in, r6_live;
    logic [TW-1:0]     r3_tca, r4_tca, r5_tca, r6_tca;
    logic [LMW-1:0]    r3_lm, r4_lm, r5_lm;
    logic [2*HW-1:0]   r4_hh;
    logic [HW+K-1:0]   r4_hl;
    logic [2*K-1:0]    r4_ll;
    logic [62:0]       r5_tsq, r6_thc;

    logic signed [32:0] n_lx, n_ly;
    logic [32:0]       ax, ay;
    logic signed [51:0] dot, tca_s;
    logic [LMW-1:0]    lm;
    logic [SQW-1:0]    sq, sqf, sat;
    logic signed [64:0] thc;

    always_comb begin
        n_lx = 33'(i_cx) - 33'(i_ox);
        n_ly = 33'(i_cy) - 33'(i_oy);
        ax = r1_lx[32] ? 33'(-r1_lx) : 33'(r1_lx);
        ay = r1_ly[32] ? 33'(-r1_ly) : 33'(r1_ly);
        dot = 52'(r2_px) + 52'(r2_py);
        tca_s = dot >>> FRAC_BITS;
        lm = LMW'(r2_sx >> FRAC_BITS) + LMW'(r2_sy >> FRAC_BITS);
        sq = (SQW'(r4_hh) << (2 * K)) + (SQW'(r4_hl) << (K + 1)) + SQW'(r4_ll);
        sqf = sq >> FRAC_BITS;
        sat = SQW'(1) << SQ_SAT_BIT;
        thc = $signed({34'b0, r5_r2}) - $signed({{(65 - LMW){1'b0}}, r5_lm})
            + $signed({2'b0, r5_tsq});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_lx <= n_lx;
            r1_ly <= n_ly;
            r1_dx <= i_dx;
            r1_dy <= i_dy;
            r1_maxd <= i_maxd;
            r1_r2 <= i_r2;

            r2_px <= 51'(r1_lx * r1_dx);
            r2_py <= 51'(r1_ly * r1_dy);
            r2_sx <= 66'(ax * ax);
            r2_sy <= 66'(ay * ay);
            r2_maxd <= r1_maxd;
            r2_r2 <= r1_r2;

            r3_neg <= dot[51];
            r3_tca <= tca_s[TW-1:0];
            r3_lm <= lm;
            r3_in <= (lm < LMW'(r2_r2));
            r3_maxd <= r2_maxd;
            r3_r2 <= r2_r2;

            r4_hh <= (2*HW)'(r3_tca[TW-1:K] * r3_tca[TW-1:K]);
            r4_hl <= (HW+K)'(r3_tca[TW-1:K] * r3_tca[K-1:0]);
            r4_ll <= (2*K)'(r3_tca[K-1:0] * r3_tca[K-1:0]);
            r4_neg <= r3_neg;
            r4_tca <= r3_tca;
            r4_lm <= r3_lm;
            r4_in <= r3_in;
            r4_maxd <= r3_maxd;
            r4_r2 <= r3_r2;

            r5_tsq <= (sqf > sat) ? sat[62:0] : sqf[62:0];
            r5_neg <= r4_neg;
            r5_tca <= r4_tca;
            r5_lm <= r4_lm;
            r5_in <= r4_in;
            r5_maxd <= r4_maxd;
            r5_r2 <= r4_r2;

            r6_thc <= thc[62:0];
            r6_live <= !r5_neg && (r5_in || !thc[64]);
            r6_in <= r5_in;
            r6_tca <= r5_tca;
            r6_maxd <= r5_maxd;
        end
    end

    always_comb begin
        o_side.valid = r6_v;
        o_side.in_circle = r6_in;
        o_side.live = r6_live;
        o_side.maxd = r6_maxd;
        o_side.tca = TCA_W'(r6_tca);
        o_thc = r6_thc;
    end

endmodule

[src/rcfh_sqrt_cell.sv]
// One cell of the square-root chain: retires one radicand bit pair per cycle while i_en is high.
// Depends on rcfh_pkg.
module rcfh_sqrt_cell
    import rcfh_pkg::*;
#(
    parameter int PAIRS = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_side                i_side,
    input  logic [2*PAIRS-1:0]   i_rad,
    input  logic [PAIRS+1:0]     i_rem,
    input  logic [PAIRS-1:0]     i_root,
    output t_side                o_side,
    output logic [2*PAIRS-1:0]   o_rad,
    output logic [PAIRS+1:0]     o_rem,
    output logic [PAIRS-1:0]     o_root
);

    localparam int RW = PAIRS + 2;
    localparam int RADW = 2 * PAIRS;

    logic [RW-1:0] rem2, trial;
    logic          ge;

    always_comb begin
        rem2 = {i_rem[RW-3:0], i_rad[RADW-1:RADW-2]};
        trial = {i_root, 2'b01};
        ge = rem2 >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_side.valid <= 1'b0;
        end else if (i_en) begin
            o_side.valid <= i_side.valid;
        end
        if (i_en) begin
            o_side.in_circle <= i_side.in_circle;
            o_side.live <= i_side.live;
            o_side.maxd <= i_side.maxd;
            o_side.tca <= i_side.tca;
            o_rad <= {i_rad[RADW-3:0], 2'b00};
            o_rem <= ge ? rem2 - trial : rem2;
            o_root <= {i_root[PAIRS-2:0], ge};
        end
    end

endmodule

[src/ray_circle_first_hit.sv]
// Top level of the ray/circle first-hit block: front stages, root chain, output.
// Depends on rcfh_pkg, rcfh_if, rcfh_front and rcfh_sqrt_cell.
//
//   port    dir  word
//   i_req   in   ray origin, direction, max distance, circle center, squared radius
//   o_rsp   out  hit, hit distance, origin inside
//
// One word is taken per cycle while i_req.ready is high; the result passes the front
// stages, the one-pair-per-cell root chain and the output registers.
// A synchronous low reset clears only valid bits. A stall on o_rsp parks one
// word in a skid register and then freezes the whole pipeline.
module ray_circle_first_hit
    import rcfh_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rcfh_in_if.sink    i_req,
    rcfh_out_if.source o_rsp
);

    localparam int PAIRS = (65 + FRAC_BITS) / 2;
    localparam int RADW = 2 * PAIRS;
    localparam int DW = ((PAIRS > TCA_W) ? PAIRS : TCA_W) + 2;

    logic               en;
    t_side              s_side [0:PAIRS];
    logic [RADW-1:0]    s_rad  [0:PAIRS];
    logic [PAIRS+1:0]   s_rem  [0:PAIRS];
    logic [PAIRS-1:0]   s_root [0:PAIRS];
    logic [62:0]        thc;

    logic signed [DW-1:0] t0;
    logic               n_hit;
    logic [31:0]        n_dist;
    logic               r_p_v, r_p_hit, r_p_in;
    logic [31:0]        r_p_dist;
    logic               r_o_v, r_o_hit, r_o_in;
    logic [31:0]        r_o_dist;
    logic               r_s_v, r_s_hit, r_s_in;
    logic [31:0]        r_s_dist;
    logic               take;

    assign en = !r_s_v;
    assign i_req.ready = en;

    rcfh_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_req.valid),
        .i_ox    (i_req.ray_origin_x),
        .i_oy    (i_req.ray_origin_y),
        .i_dx    (i_req.ray_dir_x),
        .i_dy    (i_req.ray_dir_y),
        .i_maxd  (i_req.ray_max_distance),
        .i_cx    (i_req.circle_center_x),
        .i_cy    (i_req.circle_center_y),
        .i_r2    (i_req.circle_radius_sq),
        .o_side  (s_side[0]),
        .o_thc   (thc)
    );

    assign s_rad[0] = {{(RADW - 63 - FRAC_BITS){1'b0}}, thc, {FRAC_BITS{1'b0}}};
    assign s_rem[0] = '0;
    assign s_root[0] = '0;

    for (genvar g = 0; g < PAIRS; g++) begin : g_cell
        rcfh_sqrt_cell #(.PAIRS(PAIRS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_side  (s_side[g]),
            .i_rad   (s_rad[g]),
            .i_rem   (s_rem[g]),
            .i_root  (s_root[g]),
            .o_side  (s_side[g+1]),
            .o_rad   (s_rad[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_root  (s_root[g+1])
        );
    end

    always_comb begin
        t0 = $signed(DW'(s_side[PAIRS].tca)) - $signed(DW'(s_root[PAIRS]));
        n_hit = 1'b0;
        n_dist = MISS_DIST;
        if (s_side[PAIRS].live) begin
            if (s_side[PAIRS].in_circle) begin
                n_hit = 1'b1;
                if (t0 > $signed(DW'(32'h7FFF_FFFF))) begin
                    n_dist = 32'h7FFF_FFFF;
                end else if (t0 < -$signed(DW'(33'h0_8000_0000))) begin
                    n_dist = 32'h8000_0000;
                end else begin
                    n_dist = t0[31:0];
                end
            end else if (!t0[DW-1] && t0 <= $signed(DW'(s_side[PAIRS].maxd))) begin
                n_hit = 1'b1;
                n_dist = t0[31:0];
            end
        end
    end

    assign take = r_o_v && o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else begin
            if (en) begin
                r_p_v <= s_side[PAIRS].valid;
            end
            if (r_s_v) begin
                if (take) begin
                    r_s_v <= 1'b0;
                end
            end else if (r_p_v) begin
                if (!r_o_v || take) begin
                    r_o_v <= 1'b1;
                end else begin
                    r_s_v <= 1'b1;
                end
            end else if (take) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_hit <= n_hit;
            r_p_dist <= n_dist;
            r_p_in <= s_side[PAIRS].in_circle;
        end
        if (r_s_v) begin
            if (take) begin
                r_o_hit <= r_s_hit;
                r_o_dist <= r_s_dist;
                r_o_in <= r_s_in;
            end
        end else if (r_p_v) begin
            if (!r_o_v || take) begin
                r_o_hit <= r_p_hit;
                r_o_dist <= r_p_dist;
                r_o_in <= r_p_in;
            end else begin
                r_s_hit <= r_p_hit;
                r_s_dist <= r_p_dist;
                r_s_in <= r_p_in;
            end
        end
    end

    assign o_rsp.valid = r_o_v;
    assign o_rsp.hit = r_o_hit;
    assign o_rsp.hit_distance = r_o_dist;
    assign o_rsp.origin_inside = r_o_in;

endmodule

[tb/sv/testbench.sv]
// Testbench for the ray/circle first-hit block: directed table, then random words,
// all checked against a fixed-point predictor. Depends on rcfh_pkg, rcfh_if and ray_circle_first_hit.
module testbench;
    import rcfh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam longint unsigned SAT = 64'd1 << 62;
    localparam int NRAND = 2000;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic [30:0]        maxd;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        r2;
    } t_query;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] distance;
        logic               in_circle;
    } t_answer;

    typedef struct {
        t_query  q;
        logic    known;
        t_answer a;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    rcfh_in_if  req ();
    rcfh_out_if rsp ();

    ray_circle_first_hit dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .o_rsp(rsp));

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_answer pending[$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    bit done = 1'b0;

    function automatic longint unsigned square_fx(longint unsigned a);
        longint unsigned ah, al, hsq, t;
        ah = a >> FB;
        al = a & ((64'd1 << FB) - 1);
        if (ah >= (64'd1 << 31)) return SAT;
        hsq = ah * ah;
        if (hsq > (SAT >> FB)) return SAT;
        t = (hsq << FB) + 2 * ah * al + ((al * al) >> FB);
        return (t > SAT) ? SAT : t;
    endfunction

    function automatic longint unsigned root_fx(longint unsigned x);
        logic [127:0] v, r, rem, trial;
        v = {64'd0, x} << FB;
        r = 0;
        rem = 0;
        for (int p = (64 + FB + 1) / 2 - 1; p >= 0; p--) begin
            rem = (rem << 2) | ((v >> (2 * p)) & 128'd3);
            trial = (r << 2) | 128'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                r = (r << 1) | 128'd1;
            end else begin
                r = r << 1;
            end
        end
        return r[63:0];
    endfunction

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic t_answer first_hit(t_query q);
        t_answer a;
        longint lx, ly, tca, thc, t0;
        longint unsigned lmag;
        lx = longint'(q.cx) - longint'(q.ox);
        ly = longint'(q.cy) - longint'(q.oy);
        tca = (lx * longint'(q.dx) + ly * longint'(q.dy)) >>> FB;
        lmag = square_fx(mag(lx)) + square_fx(mag(ly));
        if (lmag > SAT) lmag = SAT;
        a.in_circle = lmag < longint'(q.r2);
        a.hit = 1'b0;
        a.distance = MISS_DIST;
        if (tca >= 0) begin
            thc = longint'(q.r2) - longint'(lmag) + longint'(square_fx(tca));
            if (a.in_circle || thc >= 0) begin
                t0 = tca - longint'(root_fx(thc));
                if (a.in_circle) begin
                    if (t0 > 64'sd2147483647) t0 = 64'sd2147483647;
                    if (t0 < -64'sd2147483648) t0 = -64'sd2147483648;
                    a.hit = 1'b1;
                    a.distance = t0[31:0];
                end else if (t0 >= 0 && t0 <= longint'(q.maxd)) begin
                    a.hit = 1'b1;
                    a.distance = t0[31:0];
                end
            end
        end
        return a;
    endfunction

    function automatic t_query mk(int ox, int oy, int dx, int dy, int maxd,
                                  int cx, int cy, int r2);
        t_query q;
        q = '{ox, oy, dx[17:0], dy[17:0], maxd[30:0], cx, cy, r2[30:0]};
        return q;
    endfunction

    function automatic t_query random_query();
        t_query q;
        int sel, ang;
        sel = $urandom_range(0, 9);
        q.ox = $urandom;
        q.oy = $urandom;
        q.dx = $urandom;
        q.dy = $urandom;
        q.maxd = $urandom;
        q.cx = $urandom;
        q.cy = $urandom;
        q.r2 = $urandom;
        if (sel < 8) begin
            // Mostly nearby geometry, with near-unit directions in three of four cases, so hits are common.
            ang = $urandom_range(0, 3);
            q.ox = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            q.oy = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            q.cx = q.ox + $signed($urandom_range(0, 1 << 23)) - (1 << 22);
            q.cy = q.oy + $signed($urandom_range(0, 1 << 23)) - (1 << 22);
            case (ang)
                0: begin q.dx = 18'sd65536; q.dy = 18'sd0; end
                1: begin q.dx = -18'sd65536; q.dy = 18'sd0; end
                2: begin q.dx = 18'sd46341; q.dy = -18'sd46341; end
                default: begin
                    q.dx = $signed($urandom_range(0, 131072)) - 65536;
                    q.dy = $signed($urandom_range(0, 131072)) - 65536;
                end
            endcase
            q.r2 = $urandom_range(0, 32'h7FFF_FFFF);
            q.maxd = (sel < 4) ? $urandom_range(0, 1 << 24) : $urandom;
        end
        return q;
    endfunction

    task automatic send(t_query q);
        req.valid <= 1'b1;
        {req.ray_origin_x, req.ray_origin_y, req.ray_dir_x, req.ray_dir_y,
         req.ray_max_distance, req.circle_center_x, req.circle_center_y,
         req.circle_radius_sq} <= q;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        int n;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 19);
            req.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Accept side: the ready stalls in random bursts.
    int stall = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (pending.size() == 0) begin
                    $error("unexpected word: hit=%0d dist=%0d", rsp.hit, rsp.hit_distance);
                    errors++;
                end else begin
                    if (rsp.hit !== pending[0].hit) begin
                        $error("hit: expected %0d actual %0d", pending[0].hit, rsp.hit);
                        errors++;
                    end
                    if (rsp.hit_distance !== pending[0].distance) begin
                        $error("hit_distance: expected %0d actual %0d",
                               pending[0].distance, rsp.hit_distance);
                        errors++;
                    end
                    if (rsp.origin_inside !== pending[0].in_circle) begin
                        $error("origin_inside: expected %0d actual %0d",
                               pending[0].in_circle, rsp.origin_inside);
                        errors++;
                    end
                    void'(pending.pop_front());
                end
            end
            if (stall > 0) begin
                stall <= stall - 1;
                rsp.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall <= $urandom_range(1, 19);
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // Predictions are queued when the word is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && req.valid && req.ready)
            pending.push_back(first_hit({req.ray_origin_x, req.ray_origin_y, req.ray_dir_x,
                req.ray_dir_y, req.ray_max_distance, req.circle_center_x,
                req.circle_center_y, req.circle_radius_sq}));
    end

    t_row rows[$];
    t_answer got;

    initial begin
        t_row r;
        req.valid = 1'b0;
        {req.ray_origin_x, req.ray_origin_y, req.ray_dir_x, req.ray_dir_y,
         req.ray_max_distance, req.circle_center_x, req.circle_center_y,
         req.circle_radius_sq} = '0;
        // All zero: not inside, projection zero, tangent hit at distance zero.
        rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{1'b1, 32'sd0, 1'b0}});
        // Circle behind the ray: negative projection is a miss.
        rows.push_back('{mk(0, 0, 65536, 0, 32'h7FFFFFFF, -(10 << 16), 0, 1 << 16),
                         1'b1, '{1'b0, MISS_DIST, 1'b0}});
        // Straight hit ahead: center at 10, radius 1, distance 9.
        rows.push_back('{mk(0, 0, 65536, 0, 32'h7FFFFFFF, 10 << 16, 0, 1 << 16),
                         1'b1, '{1'b1, 32'sd9 <<< 16, 1'b0}});
        // Hit beyond max distance.
        rows.push_back('{mk(0, 0, 65536, 0, 5 << 16, 10 << 16, 0, 1 << 16),
                         1'b1, '{1'b0, MISS_DIST, 1'b0}});
        // Passes beside the circle: negative half-chord.
        rows.push_back('{mk(0, 0, 65536, 0, 32'h7FFFFFFF, 10 << 16, 5 << 16, 1 << 16),
                         1'b1, '{1'b0, MISS_DIST, 1'b0}});
        // Tangent.
        rows.push_back('{mk(0, 0, 65536, 0, 32'h7FFFFFFF, 10 << 16, 1 << 16, 1 << 16),
                         1'b1, '{1'b1, 32'sd10 <<< 16, 1'b0}});
        // Origin inside, center ahead: negative distance returned.
        rows.push_back('{mk(0, 0, 65536, 0, 0, 1 << 16, 0, 4 << 16), 1'b0, '{0, 0, 0}});
        // Origin inside, center behind: still a miss.
        rows.push_back('{mk(0, 0, 65536, 0, 0, -(1 << 16), 0, 4 << 16), 1'b0, '{0, 0, 0}});
        // Extremes of every field and non-unit directions.
        rows.push_back('{mk(32'h80000000, 32'h80000000, -65536, -65536, 0,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0, '{0, 0, 0}});
        rows.push_back('{mk(32'h7FFFFFFF, 32'h80000000, 131071, -131072, 32'h7FFFFFFF,
                            32'h80000000, 32'h7FFFFFFF, 0), 1'b0, '{0, 0, 0}});
        rows.push_back('{mk(0, 0, -131072, -131072, 32'h7FFFFFFF,
                            32'h80000000, 32'h80000000, 32'h7FFFFFFF), 1'b0, '{0, 0, 0}});
        rows.push_back('{mk(0, 0, 131071, 131071, 32'h7FFFFFFF,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0, '{0, 0, 0}});
        rows.push_back('{mk(0, 0, 65536, 0, 32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF),
                         1'b0, '{0, 0, 0}});
        rows.push_back('{mk(0, 0, 0, 65536, 32'h7FFFFFFF, 0, 40000 << 16, 32'h7FFFFFFF),
                         1'b0, '{0, 0, 0}});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send(rows[i].q);
            if (rows[i].known) begin
                got = first_hit(rows[i].q);
                if (got !== rows[i].a) begin
                    $error("table row %0d: expected %h predictor %h", i, rows[i].a, got);
                    errors++;
                end
            end
            maybe_gap();
        end
        for (int i = 0; i < NRAND; i++) begin
            if (i == NRAND / 2) begin
                req.valid <= 1'b0;
                @(posedge i_clk);
                while (pending.size() != 0) @(posedge i_clk);
            end
            if (i == NRAND - 200) quiet = 1'b1;
            send(random_query());
            maybe_gap();
        end
        req.valid <= 1'b0;
        quiet = 1'b1;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
